// ----- hw/rtl/stq_pkg.sv -----
// Package for the sorted timer queue: operation codes, result kinds and
// sequencer states. No dependencies; imported by sorted_timer_queue.
`default_nettype none

package stq_pkg;

  // Operation carried by an input word.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ADJUST = 2'd1,
    OP_DELETE = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  // Kind of a result word.
  typedef enum logic [2:0] {
    KIND_DONE      = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_NOT_FOUND = 3'd2,
    KIND_EXPIRED   = 3'd3,
    KIND_NONE      = 3'd4
  } kind_t;

  // Sequencer states. Each entry visit takes a read state and a second state that checks, emits or writes.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DEL_RD,
    S_DEL_CHK,
    S_INS_RD,
    S_INS_CHK,
    S_CNT_RD,
    S_CNT_CHK,
    S_CNT_END,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_CMP_RD,
    S_CMP_WR,
    S_RESP
  } state_t;

  // Most timers popped by one tick.
  localparam int unsigned MAX_RESULTS = 16;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_timer_queue.sv -----
// Sorted timer queue: timers kept in ascending expiry order in a memory,
// managed by a small sequencer with one time comparator. Depends on stq_pkg.
//
// Usage: command words (op, timer_id, expire_time, now) enter on cmd_valid /
// cmd_stall; result words (kind, expired_id, expired_time, last) leave on
// res_valid / res_stall. A word moves when valid is high and stall is low.
// The block takes one command at a time; cmd_stall is high while it works.
// Every command yields one result word, except a tick that pops timers,
// which yields one word per popped timer; last marks the final word.
// Each command sweeps the entry memory one entry at a time, each visit being
// an address state and then a state that uses the registered read data:
//   add:            sweeps the entries behind the new one, from the back
//   delete:         sweeps every entry
//   adjust:         a delete, then an add if the timer was found
//   tick:           scans the expired timers, emits one word per popped
//                   timer, then compacts the remaining entries to the front
// The result sits in an output register, so a stalled receiver only holds
// the sequencer where it has a new word to place. Reset (rst, synchronous)
// empties the queue at once; no clearing pass is needed.
`default_nettype none

module sorted_timer_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Command channel.
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire logic [1:0]  op,
  input  wire logic [3:0]  timer_id,
  input  wire logic [31:0] expire_time,
  input  wire logic [31:0] now,
  // Result channel.
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [2:0]       kind,
  output logic [3:0]       expired_id,
  output logic [31:0]      expired_time,
  output logic             last
);

  import stq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Entry memory, one write and one registered read per cycle.
  logic [3:0]  entry_ids   [DEPTH];
  logic [31:0] entry_times [DEPTH];

  // Sequencer and command registers.
  state_t         state, state_next;
  op_t            op_r;
  logic [3:0]     id_r;
  logic [31:0]    time_r;
  logic [CW-1:0]  idx, idx_next;
  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  npop, npop_next;
  logic           found, found_next;
  kind_t          resp_kind, resp_kind_next;

  // Memory access signals.
  logic [AW-1:0]  rd_addr;
  logic [3:0]     rd_id;
  logic [31:0]    rd_time;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [3:0]     wr_id;
  logic [31:0]    wr_time;

  // Result register loading.
  logic           load_res;
  kind_t          res_kind_next;
  logic [3:0]     res_id_next;
  logic [31:0]    res_time_next;
  logic           res_last_next;

  // Helpers.
  logic           out_free;
  logic           accept;
  logic [CW-1:0]  idx_p1;
  logic [CW-1:0]  idx_m1;
  logic [CW:0]    src;
  logic           scan_end;
  logic           time_gt;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && (state == S_IDLE);
  assign out_free  = !res_valid || !res_stall;
  assign idx_p1    = idx + 1'b1;
  assign idx_m1    = idx - 1'b1;
  assign src       = {1'b0, idx} + {1'b0, npop};
  assign scan_end  = (idx == count) || (32'(idx) >= MAX_RESULTS);

  // The one time comparator, shared by the insertion and expiry sweeps.
  assign time_gt   = (rd_time > time_r);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (op_t'(op))
            OP_ADD:    state_next = (count == DEPTH_C) ? S_RESP : S_INS_RD;
            OP_ADJUST: state_next = S_DEL_RD;
            OP_DELETE: state_next = S_DEL_RD;
            OP_TICK:   state_next = S_CNT_RD;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_DEL_RD: begin
        if (idx == count) begin
          state_next = (found && op_r == OP_ADJUST) ? S_INS_RD : S_RESP;
        end else begin
          state_next = S_DEL_CHK;
        end
      end
      S_DEL_CHK:  state_next = S_DEL_RD;
      S_INS_RD:   state_next = (idx == '0) ? S_RESP : S_INS_CHK;
      S_INS_CHK:  state_next = time_gt ? S_INS_RD : S_RESP;
      S_CNT_RD:   state_next = scan_end ? S_CNT_END : S_CNT_CHK;
      S_CNT_CHK:  state_next = !time_gt ? S_CNT_RD : S_CNT_END;
      S_CNT_END:  state_next = (idx == '0) ? S_RESP : S_EMIT_RD;
      S_EMIT_RD:  state_next = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (out_free) begin
          state_next = (idx_p1 == npop) ? S_CMP_RD : S_EMIT_RD;
        end
      end
      S_CMP_RD:   state_next = (src >= {1'b0, count}) ? S_IDLE : S_CMP_WR;
      S_CMP_WR:   state_next = S_CMP_RD;
      S_RESP:     state_next = out_free ? S_IDLE : S_RESP;
      default:    state_next = S_IDLE;
    endcase
  end

  // Datapath control for each state.
  always_comb begin
    idx_next       = idx;
    count_next     = count;
    npop_next      = npop;
    found_next     = found;
    resp_kind_next = resp_kind;
    rd_addr        = idx[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = idx[AW-1:0];
    wr_id          = rd_id;
    wr_time        = rd_time;
    load_res       = 1'b0;
    res_kind_next  = resp_kind;
    res_id_next    = '0;
    res_time_next  = '0;
    res_last_next  = 1'b1;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          idx_next   = '0;
          found_next = 1'b0;
          npop_next  = '0;
          if (op_t'(op) == OP_ADD) begin
            if (count == DEPTH_C) begin
              resp_kind_next = KIND_FULL;
            end else begin
              idx_next = count;
            end
          end
        end
      end
      // Removal sweep: after the match, each entry moves one place forward.
      S_DEL_RD: begin
        if (idx == count) begin
          if (found) begin
            count_next = count - 1'b1;
            idx_next   = count - 1'b1;
            resp_kind_next = KIND_DONE;
          end else begin
            resp_kind_next = KIND_NOT_FOUND;
          end
        end
      end
      S_DEL_CHK: begin
        if (found) begin
          wr_en   = 1'b1;
          wr_addr = idx_m1[AW-1:0];
        end else if (rd_id == id_r) begin
          found_next = 1'b1;
        end
        idx_next = idx_p1;
      end
      // Insertion sweep from the back: later entries move one place back.
      S_INS_RD: begin
        rd_addr = idx_m1[AW-1:0];
        if (idx == '0) begin
          wr_en          = 1'b1;
          wr_id          = id_r;
          wr_time        = time_r;
          count_next     = count + 1'b1;
          resp_kind_next = KIND_DONE;
        end
      end
      S_INS_CHK: begin
        wr_en = 1'b1;
        if (time_gt) begin
          idx_next = idx_m1;
        end else begin
          wr_id          = id_r;
          wr_time        = time_r;
          count_next     = count + 1'b1;
          resp_kind_next = KIND_DONE;
        end
      end
      // Expiry scan from the front.
      S_CNT_CHK: begin
        if (!time_gt) begin
          idx_next = idx_p1;
        end
      end
      S_CNT_END: begin
        npop_next = idx;
        idx_next  = '0;
        if (idx == '0) begin
          resp_kind_next = KIND_NONE;
        end
      end
      // One result word per popped timer.
      S_EMIT_OUT: begin
        if (out_free) begin
          load_res      = 1'b1;
          res_kind_next = KIND_EXPIRED;
          res_id_next   = rd_id;
          res_time_next = rd_time;
          res_last_next = (idx_p1 == npop);
          idx_next      = (idx_p1 == npop) ? '0 : idx_p1;
        end
      end
      // Compaction: the remaining entries move to the front.
      S_CMP_RD: begin
        rd_addr = src[AW-1:0];
        if (src >= {1'b0, count}) begin
          count_next = count - npop;
        end
      end
      S_CMP_WR: begin
        wr_en    = 1'b1;
        idx_next = idx_p1;
      end
      S_RESP: begin
        load_res = out_free;
      end
      default: begin
        idx_next = idx;
      end
    endcase
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
      npop  <= '0;
      found <= 1'b0;
      resp_kind <= KIND_DONE;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      npop  <= npop_next;
      found <= found_next;
      resp_kind <= resp_kind_next;
    end
  end

  // Command fields are held for the whole operation. The time register keeps
  // the current time for a tick and the expiry time for the other commands.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(op);
      id_r   <= timer_id;
      time_r <= (op_t'(op) == OP_TICK) ? now : expire_time;
    end
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_ids[wr_addr]   <= wr_id;
      entry_times[wr_addr] <= wr_time;
    end
    rd_id   <= entry_ids[rd_addr];
    rd_time <= entry_times[rd_addr];
  end

  // Result output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      kind         <= res_kind_next;
      expired_id   <= res_id_next;
      expired_time <= res_time_next;
      last         <= res_last_next;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for sorted_timer_queue: directed and random command words,
// predicted against an in-bench timer queue. Depends on stq_pkg and the block RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stq_pkg::*;

  localparam int TQ_DEPTH       = 16;
  localparam int QUIET_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 200;

  // One expected result word.
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  id;
    logic [31:0] t;
    logic        last;
  } result_word_t;

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_stall;
  logic [1:0]  op;
  logic [3:0]  timer_id;
  logic [31:0] expire_time;
  logic [31:0] now;
  logic        res_valid;
  logic        res_stall;
  logic [2:0]  kind;
  logic [3:0]  expired_id;
  logic [31:0] expired_time;
  logic        last;

  // Predicted queue contents, front first.
  logic [3:0]   tq_ids [TQ_DEPTH];
  logic [31:0]  tq_times [TQ_DEPTH];
  int           tq_count;
  result_word_t pending_results [$];

  int          errors;
  int          cmds_sent;
  int          words_seen;
  int          quiet_cycles;
  int          send_idle_pct;
  int          stall_pct;
  logic [31:0] window_base;

  sorted_timer_queue #(.DEPTH(TQ_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .op(op), .timer_id(timer_id), .expire_time(expire_time), .now(now),
    .res_valid(res_valid), .res_stall(res_stall),
    .kind(kind), .expired_id(expired_id), .expired_time(expired_time), .last(last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Queue bookkeeping: insert behind every entry with an equal or earlier time.
  function automatic void tq_insert(logic [3:0] id, logic [31:0] t);
    int pos;
    pos = 0;
    while (pos < tq_count && tq_times[pos] <= t) pos++;
    for (int i = tq_count; i > pos; i--) begin
      tq_ids[i]   = tq_ids[i-1];
      tq_times[i] = tq_times[i-1];
    end
    tq_ids[pos]   = id;
    tq_times[pos] = t;
    tq_count++;
  endfunction

  // Remove the entry with this id nearest the front; returns 0 if absent.
  function automatic bit tq_remove(logic [3:0] id);
    int pos;
    pos = 0;
    while (pos < tq_count && tq_ids[pos] != id) pos++;
    if (pos >= tq_count) return 1'b0;
    for (int i = pos; i + 1 < tq_count; i++) begin
      tq_ids[i]   = tq_ids[i+1];
      tq_times[i] = tq_times[i+1];
    end
    tq_count--;
    return 1'b1;
  endfunction

  function automatic void expect_status(kind_t k);
    pending_results.push_back('{kind: k, id: 4'd0, t: 32'd0, last: 1'b1});
  endfunction

  // Apply one accepted command to the predicted queue and queue its result words.
  function automatic void apply_timer_command(op_t o, logic [3:0] id, logic [31:0] et,
                                              logic [31:0] t_now);
    int popped;
    popped = 0;
    case (o)
      OP_ADD: begin
        if (tq_count >= TQ_DEPTH) begin
          expect_status(KIND_FULL);
        end else begin
          tq_insert(id, et);
          expect_status(KIND_DONE);
        end
      end
      OP_ADJUST: begin
        if (tq_remove(id)) begin
          tq_insert(id, et);
          expect_status(KIND_DONE);
        end else begin
          expect_status(KIND_NOT_FOUND);
        end
      end
      OP_DELETE: begin
        expect_status(tq_remove(id) ? KIND_DONE : KIND_NOT_FOUND);
      end
      default: begin
        while (popped < MAX_RESULTS && popped < tq_count && tq_times[popped] <= t_now) begin
          pending_results.push_back('{kind: KIND_EXPIRED, id: tq_ids[popped],
                                      t: tq_times[popped], last: 1'b0});
          popped++;
        end
        if (popped == 0) begin
          expect_status(KIND_NONE);
        end else begin
          pending_results[$].last = 1'b1;
          for (int i = 0; i + popped < tq_count; i++) begin
            tq_ids[i]   = tq_ids[i+popped];
            tq_times[i] = tq_times[i+popped];
          end
          tq_count -= popped;
        end
      end
    endcase
  endfunction

  // Send one command word, with random idle cycles ahead of it, and predict it once taken.
  task automatic send_cmd(op_t o, logic [3:0] id, logic [31:0] et, logic [31:0] t_now);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid   <= 1'b1;
    op          <= o;
    timer_id    <= id;
    expire_time <= et;
    now         <= t_now;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    apply_timer_command(o, id, et, t_now);
    cmds_sent++;
  endtask

  // Receiver pacing.
  always @(posedge clk) begin
    res_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    result_word_t want;
    if (!rst && res_valid && !res_stall) begin
      words_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word kind %0d id %0d time %0d last %0d", $time,
                 kind, expired_id, expired_time, last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind) begin
          $display("%0t: kind expected %0d, got %0d", $time, want.kind, kind);
          errors++;
        end
        if (expired_id !== want.id) begin
          $display("%0t: expired_id expected %0d, got %0d", $time, want.id, expired_id);
          errors++;
        end
        if (expired_time !== want.t) begin
          $display("%0t: expired_time expected %0d, got %0d", $time, want.t, expired_time);
          errors++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %0d, got %0d", $time, want.last, last);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d words still expected", $time,
               quiet_cycles, pending_results.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Empty table: tick with nothing queued, then unknown ids.
  task automatic test_empty_queue();
    send_cmd(OP_TICK, 4'($urandom), $urandom, 32'd0);
    send_cmd(OP_DELETE, 4'd5, $urandom, $urandom);
    send_cmd(OP_ADJUST, 4'd5, 32'd7, $urandom);
  endtask

  // Fill the table with duplicate ids, equal times and extreme times, then overflow it.
  task automatic test_full_table();
    logic [3:0]  ids [16] = '{4'd1, 4'd2, 4'd3, 4'd1, 4'd4, 4'd5, 4'd6, 4'd7,
                              4'd8, 4'd9, 4'd10, 4'd15, 4'd0, 4'd11, 4'd12, 4'd13};
    logic [31:0] ts [16]  = '{32'd100, 32'd0, 32'd100, 32'd50, 32'hFFFF_FFFF, 32'd100,
                              32'd0, 32'd50, 32'd200, 32'd150, 32'd100, 32'd300,
                              32'd250, 32'hFFFF_FFFF, 32'd75, 32'd100};
    for (int i = 0; i < 16; i++) send_cmd(OP_ADD, ids[i], ts[i], $urandom);
    send_cmd(OP_ADD, 4'd14, 32'd10, $urandom);
  endtask

  // Duplicate id removal and adjusts to earlier and later times.
  task automatic test_duplicates_and_adjust();
    send_cmd(OP_DELETE, 4'd1, $urandom, $urandom);
    send_cmd(OP_ADJUST, 4'd5, 32'd0, $urandom);
    send_cmd(OP_ADJUST, 4'd2, 32'd120, $urandom);
  endtask

  // Ticks that pop part of the table, then everything left at the largest time.
  task automatic test_expiry();
    send_cmd(OP_TICK, 4'($urandom), $urandom, 32'd100);
    send_cmd(OP_TICK, 4'($urandom), $urandom, 32'hFFFF_FFFF);
  endtask

  // Times mostly near a drifting window so ticks pop and times tie; some extremes.
  function automatic logic [31:0] pick_time(int spread);
    int r;
    r = $urandom_range(99);
    if (r < 4) return 32'd0;
    if (r < 8) return 32'hFFFF_FFFF;
    if (r < 22) return $urandom;
    return window_base + $urandom_range(0, spread);
  endfunction

  // Ids mostly taken from the queue so adjust and delete find their timer.
  function automatic logic [3:0] pick_id();
    if (tq_count > 0 && $urandom_range(99) < 80) return tq_ids[$urandom_range(0, tq_count - 1)];
    return 4'($urandom);
  endfunction

  task automatic test_random_traffic(int n, int idle_pct, int stall_in_pct);
    int r;
    send_idle_pct = idle_pct;
    stall_pct     = stall_in_pct;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 35) begin
        send_cmd(OP_ADD, 4'($urandom), pick_time(20), $urandom);
      end else if (r < 55) begin
        send_cmd(OP_ADJUST, pick_id(), pick_time(20), $urandom);
      end else if (r < 75) begin
        send_cmd(OP_DELETE, pick_id(), $urandom, $urandom);
      end else begin
        send_cmd(OP_TICK, 4'($urandom), $urandom, pick_time(25));
        window_base = window_base + $urandom_range(0, 6);
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    cmd_valid     <= 1'b0;
    op            <= OP_ADD;
    timer_id      <= 4'd0;
    expire_time   <= 32'd0;
    now           <= 32'd0;
    res_stall     <= 1'b0;
    tq_count      = 0;
    errors        = 0;
    cmds_sent     = 0;
    words_seen    = 0;
    quiet_cycles  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    window_base   = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_queue();
    test_full_table();
    test_duplicates_and_adjust();
    test_expiry();
    test_random_traffic(90, 0, 0);
    test_random_traffic(85, 49, 0);
    test_random_traffic(85, 0, 49);
    test_random_traffic(85, 36, 36);
    cmd_valid <= 1'b0;

    // Drain outstanding results, then watch for stray words.
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d commands and %0d result words: empty, full and duplicate-id",
             cmds_sent, words_seen);
    $display("tables, adjusts both ways and multi-timer ticks under four pacing mixes.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sorted_timer_queue.f -----
hw/rtl/stq_pkg.sv
hw/rtl/sorted_timer_queue.sv
tb/tb_top.sv
